// ----- rtl/bgs_pkg.sv -----
// Shared constants, types and helpers for the bit gather/scatter unit.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package bgs_pkg;

  // Word width handled by the datapath (8..64)
  localparam int WIDTH = 64;
  // Number of shift stages in the compress and expand networks
  localparam int NSTG  = $clog2(WIDTH);
  // Shift stages in the first compress and last expand register stage
  localparam int NLO   = NSTG / 2;
  // Shift amount bits per lane (zeros below a lane, at most WIDTH-1)
  localparam int AW    = NSTG;
  // Register stages from operand capture to the output register
  localparam int NPIPE = 7;

  // Stream field layout
  localparam int OP_W        = 3;
  localparam int FIELD_W     = 64;
  localparam int OP_LSB      = 0;
  localparam int DATA_LSB    = OP_LSB + OP_W;
  localparam int MASK_LSB    = DATA_LSB + FIELD_W;
  localparam int IN_BITS     = MASK_LSB + FIELD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = FIELD_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_EXT_R   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEP_R   = 3'd1;
  localparam logic [OP_W-1:0] OP_EXT_L   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEP_L   = 3'd3;
  localparam logic [OP_W-1:0] OP_GROUP   = 3'd4;
  localparam logic [OP_W-1:0] OP_UNGROUP = 3'd5;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [AW-1:0]    amt_t;
  typedef amt_t [WIDTH-1:0] amt_vec_t;
  typedef word_t [NSTG-1:0] mv_vec_t;

  // Load enables for the pipeline registers held inside submodules
  typedef struct packed {
    logic amt;
    logic cmp_lo;
    logic cmp_hi;
    logic exp_hi;
    logic exp_lo;
  } bgs_en_t;

  // Bit reversal over the datapath width
  function automatic word_t rev_word(input word_t w);
    word_t r;
    for (int i = 0; i < WIDTH; i++) begin
      r[i] = w[WIDTH-1-i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/bgs_zcount.sv -----
// Per-lane count of mask zeros below each bit position (parallel prefix sum).
// Registers the counts with the operands. Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_zcount (
  input  logic              clk,
  input  bgs_pkg::bgs_en_t  en,
  input  bgs_pkg::word_t    data,
  input  bgs_pkg::word_t    mask,
  output bgs_pkg::word_t    data_q,
  output bgs_pkg::word_t    mask_q,
  output bgs_pkg::amt_vec_t amt_q
);

  bgs_pkg::amt_vec_t amt;

  // Exclusive prefix count of zeros, log-depth tree of narrow adds
  always_comb begin
    bgs_pkg::amt_vec_t cur;
    bgs_pkg::amt_vec_t nxt;
    cur = '0;
    for (int i = 1; i < bgs_pkg::WIDTH; i++) begin
      cur[i][0] = ~mask[i-1];
    end
    for (int s = 0; s < bgs_pkg::NSTG; s++) begin
      for (int i = 0; i < bgs_pkg::WIDTH; i++) begin
        nxt[i] = cur[i];
        if (i >= (1 << s)) begin
          nxt[i] = cur[i] + cur[i - (1 << s)];
        end
      end
      cur = nxt;
    end
    amt = cur;
  end

  always_ff @(posedge clk) begin
    if (en.amt) begin
      data_q <= data;
      mask_q <= mask;
      amt_q  <= amt;
    end
  end

endmodule

// ----- rtl/bgs_compress.sv -----
// Compress network: moves mask-selected bits toward bit 0 in log2(WIDTH)
// shift stages over two register stages, recording each stage's move mask.
// Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_compress (
  input  logic              clk,
  input  bgs_pkg::bgs_en_t  en,
  input  bgs_pkg::word_t    data,
  input  bgs_pkg::word_t    mask,
  input  bgs_pkg::amt_vec_t amt,
  output bgs_pkg::word_t    pext_q,
  output bgs_pkg::word_t    valid_q,
  output bgs_pkg::mv_vec_t  mv_q,
  output bgs_pkg::word_t    raw_q
);

  bgs_pkg::word_t    v_lo, d_lo;
  bgs_pkg::amt_vec_t a_lo;
  bgs_pkg::mv_vec_t  mv_lo;
  bgs_pkg::word_t    v_lo_q, d_lo_q, raw_lo_q;
  bgs_pkg::amt_vec_t a_lo_q;
  bgs_pkg::mv_vec_t  mv_lo_q;
  bgs_pkg::word_t    v_hi, d_hi;
  bgs_pkg::mv_vec_t  mv_hi;

  // Low shift stages: each lane moves down by 2^j when bit j of its amount is set
  always_comb begin
    bgs_pkg::word_t    mvw, stay;
    bgs_pkg::amt_vec_t na;
    v_lo  = mask;
    d_lo  = data & mask;
    a_lo  = amt;
    mv_lo = '0;
    for (int j = 0; j < bgs_pkg::NLO; j++) begin
      for (int p = 0; p < bgs_pkg::WIDTH; p++) begin
        mvw[p] = v_lo[p] & a_lo[p][j];
      end
      mv_lo[j] = mvw;
      stay = v_lo & ~mvw;
      for (int p = 0; p < bgs_pkg::WIDTH; p++) begin
        na[p] = stay[p] ? a_lo[p] : '0;
        if (p + (1 << j) < bgs_pkg::WIDTH) begin
          if (mvw[p + (1 << j)]) begin
            na[p] = a_lo[p + (1 << j)];
          end
        end
      end
      v_lo = stay | (mvw >> (1 << j));
      d_lo = (d_lo & stay) | ((d_lo & mvw) >> (1 << j));
      a_lo = na;
    end
  end

  always_ff @(posedge clk) begin
    if (en.cmp_lo) begin
      v_lo_q   <= v_lo;
      d_lo_q   <= d_lo;
      a_lo_q   <= a_lo;
      mv_lo_q  <= mv_lo;
      raw_lo_q <= data;
    end
  end

  // High shift stages; amounts no longer needed after the last one
  always_comb begin
    bgs_pkg::word_t    mvw, stay;
    bgs_pkg::amt_vec_t a;
    bgs_pkg::amt_vec_t na;
    v_hi  = v_lo_q;
    d_hi  = d_lo_q;
    a     = a_lo_q;
    mv_hi = mv_lo_q;
    for (int j = bgs_pkg::NLO; j < bgs_pkg::NSTG; j++) begin
      for (int p = 0; p < bgs_pkg::WIDTH; p++) begin
        mvw[p] = v_hi[p] & a[p][j];
      end
      mv_hi[j] = mvw;
      stay = v_hi & ~mvw;
      for (int p = 0; p < bgs_pkg::WIDTH; p++) begin
        na[p] = stay[p] ? a[p] : '0;
        if (p + (1 << j) < bgs_pkg::WIDTH) begin
          if (mvw[p + (1 << j)]) begin
            na[p] = a[p + (1 << j)];
          end
        end
      end
      v_hi = stay | (mvw >> (1 << j));
      d_hi = (d_hi & stay) | ((d_hi & mvw) >> (1 << j));
      a    = na;
    end
  end

  always_ff @(posedge clk) begin
    if (en.cmp_hi) begin
      pext_q  <= d_hi;
      valid_q <= v_hi;
      mv_q    <= mv_hi;
      raw_q   <= raw_lo_q;
    end
  end

endmodule

// ----- rtl/bgs_expand.sv -----
// Expand network: replays the compress move masks in reverse to scatter the
// low data bits into mask positions; also carries the compress result along.
// Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_expand (
  input  logic             clk,
  input  bgs_pkg::bgs_en_t en,
  input  bgs_pkg::word_t   raw,
  input  bgs_pkg::word_t   valid,
  input  bgs_pkg::mv_vec_t mv,
  input  bgs_pkg::word_t   pext,
  output bgs_pkg::word_t   pdep_q,
  output bgs_pkg::word_t   pext_q
);

  bgs_pkg::word_t   x_hi, x_hi_q, pext_hi_q, x_lo;
  bgs_pkg::mv_vec_t mv_hi_q;

  // High stages first; only the low popcount data bits take part
  always_comb begin
    bgs_pkg::word_t dst;
    x_hi = raw & valid;
    for (int j = bgs_pkg::NSTG - 1; j >= bgs_pkg::NLO; j--) begin
      dst  = mv[j] >> (1 << j);
      x_hi = (x_hi & ~dst) | ((x_hi & dst) << (1 << j));
    end
  end

  always_ff @(posedge clk) begin
    if (en.exp_hi) begin
      x_hi_q    <= x_hi;
      mv_hi_q   <= mv;
      pext_hi_q <= pext;
    end
  end

  // Remaining low stages
  always_comb begin
    bgs_pkg::word_t dst;
    x_lo = x_hi_q;
    for (int j = bgs_pkg::NLO - 1; j >= 0; j--) begin
      dst  = mv_hi_q[j] >> (1 << j);
      x_lo = (x_lo & ~dst) | ((x_lo & dst) << (1 << j));
    end
  end

  always_ff @(posedge clk) begin
    if (en.exp_lo) begin
      pdep_q <= x_lo;
      pext_q <= pext_hi_q;
    end
  end

endmodule

// ----- rtl/bit_gather_scatter_unit.sv -----
// Top level of the bit gather/scatter unit: stream ports, operand setup,
// valid/ready pipeline control and result selection. Depends on bgs_pkg,
// bgs_zcount, bgs_compress and bgs_expand.
`timescale 1ns / 1ps

// One transfer per clock in steady state while the output side keeps tready
// high; each item's result is offered on the output from the last of the seven
// register stages, which are: operand capture, zero-count prefix sums, two
// halves of the compress shift network, two halves of the expand shift
// network, and the output register. Each stage has its own valid bit and takes
// a new item when it is empty or its successor moves, so bubbles close up and
// the input side keeps taking transfers while a result waits at the output,
// until every stage is full. Two network copies run side by side: one on the
// word as given, one on the bit-reversed word, which serves the left-handed
// operations and the upper half of group/ungroup. Codes 6 and 7 give zero;
// bits above WIDTH are ignored.
module bit_gather_scatter_unit (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata, low bit up: operation[2:0], data_word[63:0], mask_word[63:0], zero pad
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bgs_pkg::IN_TDATA_W-1:0]   s_tdata,
  // m_tdata, low bit up: result_word[63:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bgs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  logic [bgs_pkg::NPIPE:1]   vld;
  logic [bgs_pkg::NPIPE+1:1] rdy;
  bgs_pkg::bgs_en_t en;

  logic [bgs_pkg::OP_W-1:0] op_in;
  logic [bgs_pkg::OP_W-1:0] op1, op2, op3, op4, op5, op6;
  bgs_pkg::word_t d_in, m_in, mb_in;
  bgs_pkg::word_t da1, ma1, db1, mb1;

  bgs_pkg::word_t    da2, ma2, db2, mb2;
  bgs_pkg::amt_vec_t aa2, ab2;
  bgs_pkg::word_t    pext_a4, valid_a4, raw_a4, pext_b4, valid_b4, raw_b4;
  bgs_pkg::mv_vec_t  mv_a4, mv_b4;
  bgs_pkg::word_t    pdep_a6, pext_a6, pdep_b6, pext_b6;

  bgs_pkg::word_t               res_sel;
  logic [bgs_pkg::OUT_TDATA_W-1:0] res_full;
  logic [bgs_pkg::OUT_TDATA_W-1:0] out_q;

  // Stage ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[bgs_pkg::NPIPE+1] = m_tready;
    for (int k = bgs_pkg::NPIPE; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready  = rdy[1];
  assign m_tvalid  = vld[bgs_pkg::NPIPE];
  assign m_tdata   = out_q;
  assign en.amt    = rdy[2];
  assign en.cmp_lo = rdy[3];
  assign en.cmp_hi = rdy[4];
  assign en.exp_hi = rdy[5];
  assign en.exp_lo = rdy[6];

  // Valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= bgs_pkg::NPIPE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Operand setup: trim to WIDTH, reverse for copy two, invert its group/ungroup mask
  assign op_in = s_tdata[bgs_pkg::OP_LSB +: bgs_pkg::OP_W];
  assign d_in  = s_tdata[bgs_pkg::DATA_LSB +: bgs_pkg::WIDTH];
  assign m_in  = s_tdata[bgs_pkg::MASK_LSB +: bgs_pkg::WIDTH];
  assign mb_in = (op_in == bgs_pkg::OP_GROUP || op_in == bgs_pkg::OP_UNGROUP) ? ~m_in : m_in;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      op1 <= op_in;
      da1 <= d_in;
      ma1 <= m_in;
      db1 <= bgs_pkg::rev_word(d_in);
      mb1 <= bgs_pkg::rev_word(mb_in);
    end
  end

  // Operation code follows its item down the pipe
  always_ff @(posedge clk) begin
    if (rdy[2]) op2 <= op1;
    if (rdy[3]) op3 <= op2;
    if (rdy[4]) op4 <= op3;
    if (rdy[5]) op5 <= op4;
    if (rdy[6]) op6 <= op5;
  end

  // Straight network copy
  bgs_zcount u_zcount_a (
    .clk    (clk),
    .en     (en),
    .data   (da1),
    .mask   (ma1),
    .data_q (da2),
    .mask_q (ma2),
    .amt_q  (aa2)
  );

  bgs_compress u_compress_a (
    .clk     (clk),
    .en      (en),
    .data    (da2),
    .mask    (ma2),
    .amt     (aa2),
    .pext_q  (pext_a4),
    .valid_q (valid_a4),
    .mv_q    (mv_a4),
    .raw_q   (raw_a4)
  );

  bgs_expand u_expand_a (
    .clk    (clk),
    .en     (en),
    .raw    (raw_a4),
    .valid  (valid_a4),
    .mv     (mv_a4),
    .pext   (pext_a4),
    .pdep_q (pdep_a6),
    .pext_q (pext_a6)
  );

  // Bit-reversed network copy
  bgs_zcount u_zcount_b (
    .clk    (clk),
    .en     (en),
    .data   (db1),
    .mask   (mb1),
    .data_q (db2),
    .mask_q (mb2),
    .amt_q  (ab2)
  );

  bgs_compress u_compress_b (
    .clk     (clk),
    .en      (en),
    .data    (db2),
    .mask    (mb2),
    .amt     (ab2),
    .pext_q  (pext_b4),
    .valid_q (valid_b4),
    .mv_q    (mv_b4),
    .raw_q   (raw_b4)
  );

  bgs_expand u_expand_b (
    .clk    (clk),
    .en     (en),
    .raw    (raw_b4),
    .valid  (valid_b4),
    .mv     (mv_b4),
    .pext   (pext_b4),
    .pdep_q (pdep_b6),
    .pext_q (pext_b6)
  );

  // Result select; the reversed copy is flipped back here
  always_comb begin
    case (op6)
      bgs_pkg::OP_EXT_R:   res_sel = pext_a6;
      bgs_pkg::OP_DEP_R:   res_sel = pdep_a6;
      bgs_pkg::OP_EXT_L:   res_sel = bgs_pkg::rev_word(pext_b6);
      bgs_pkg::OP_DEP_L:   res_sel = bgs_pkg::rev_word(pdep_b6);
      bgs_pkg::OP_GROUP:   res_sel = pext_a6 | bgs_pkg::rev_word(pext_b6);
      bgs_pkg::OP_UNGROUP: res_sel = pdep_a6 | bgs_pkg::rev_word(pdep_b6);
      default:             res_sel = '0;
    endcase
    res_full = '0;
    res_full[bgs_pkg::WIDTH-1:0] = res_sel;
  end

  always_ff @(posedge clk) begin
    if (rdy[bgs_pkg::NPIPE]) begin
      out_q <= res_full;
    end
  end

endmodule

// ----- rtl/bgs_checker.sv -----
// Port-level checks for the bit gather/scatter unit, bound to the top level.
// Depends on bgs_pkg and bit_gather_scatter_unit.
`timescale 1ns / 1ps

module bgs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [bgs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Nothing above the datapath width is ever set
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >> bgs_pkg::WIDTH) == '0)
    else $error("result bits above WIDTH set");

  // With the output side open the input side is never held off
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output ready");

endmodule

bind bit_gather_scatter_unit bgs_checker u_bgs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
